// ----- rtl/core/lagged_fibonacci_modulo_rng_macros.svh -----
// Assertion macros for the lagged Fibonacci generator.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef LAGGED_FIBONACCI_MODULO_RNG_MACROS_SVH
`define LAGGED_FIBONACCI_MODULO_RNG_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define LFM_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define LFM_ASSERT(lbl, prop, msg)

`define LFM_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

// ----- rtl/core/lfm_pkg.sv -----
`default_nettype none

package lfm_pkg;

    localparam int DATA_W            = 32;
    localparam int TABLE_DEPTH_DEF   = 17;
    localparam int PARTNER_START_DEF = 5;

    typedef enum logic [2:0] {
        ST_SEED,
        ST_IDLE,
        ST_ADD,
        ST_DIV,
        ST_FINISH
    } lfm_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/lfm_if.sv -----
`default_nettype none

interface lfm_req_if;
    logic                      valid;
    logic                      ready;
    logic [lfm_pkg::DATA_W-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

interface lfm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [lfm_pkg::DATA_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lagged_fibonacci_modulo_rng.sv -----
// A request is accepted only while idle; it runs the table add, then a 32-step
// restoring remainder loop that shifts the sum in one bit per cycle. Its result
// is registered once the response register is free; only then is a new request
// accepted. Reset: rst_n clears control at once; the table is then seeded
// one entry per cycle, all TABLE_DEPTH entries, with no request taken until done.
`default_nettype none
`include "lagged_fibonacci_modulo_rng_macros.svh"

module lagged_fibonacci_modulo_rng #(
    parameter int TABLE_DEPTH   = lfm_pkg::TABLE_DEPTH_DEF,
    parameter int PARTNER_START = lfm_pkg::PARTNER_START_DEF
) (
    input  wire       clk,
    input  wire       rst_n,
    lfm_req_if.sink   req,
    lfm_rsp_if.source rsp
);

    localparam int DW        = lfm_pkg::DATA_W;
    localparam int IW        = $clog2(TABLE_DEPTH + 1);
    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int CW        = $clog2(DW);
    localparam int PART_INIT = ((PARTNER_START - 1) % TABLE_DEPTH) + 1;

    localparam logic [IW-1:0] IDX_TOP   = IW'(TABLE_DEPTH);
    localparam logic [IW-1:0] IDX_ONE   = IW'(1);
    localparam logic [IW-1:0] IDX_PART  = IW'(PART_INIT);
    localparam logic [CW-1:0] CNT_LAST  = CW'(DW - 1);

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] idx);
        step_down = (idx <= IDX_ONE) ? IDX_TOP : idx - IDX_ONE;
    endfunction

    lfm_pkg::lfm_state_t state_reg, state_next;

    logic [IW-1:0] write_idx_reg, write_idx_next;
    logic [IW-1:0] partner_idx_reg, partner_idx_next;
    logic [IW-1:0] seed_idx_reg, seed_idx_next;
    logic [DW-1:0] seed_prev_reg, seed_prev_next;
    logic [DW-1:0] seed_pprev_reg, seed_pprev_next;
    logic [CW-1:0] bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0] divisor_reg, divisor_next;
    logic [DW-1:0] dividend_reg, dividend_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic [DW-1:0] random_value_reg, random_value_next;

    logic [DW-1:0] lag_mem [TABLE_DEPTH];
    logic [DW-1:0] rd_a_reg, rd_b_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;

    logic [DW-1:0] seed_sum;
    logic [DW-1:0] table_sum;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;
    logic          req_fire;
    logic          rsp_free;

    assign seed_sum  = seed_prev_reg + seed_pprev_reg;
    assign table_sum = rd_a_reg + rd_b_reg;
    assign trial     = {rem_reg, dividend_reg[DW-1]};
    assign diff      = {1'b0, trial} - {2'b00, divisor_reg};
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == lfm_pkg::ST_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.random_value = random_value_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lag_mem[mem_waddr] <= mem_wdata;
        end
        if (req_fire)
        begin
            rd_a_reg <= lag_mem[AW'(write_idx_reg - IDX_ONE)];
            rd_b_reg <= lag_mem[AW'(partner_idx_reg - IDX_ONE)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= lfm_pkg::ST_SEED;
            write_idx_reg   <= IDX_TOP;
            partner_idx_reg <= IDX_PART;
            seed_idx_reg    <= IDX_TOP;
            seed_prev_reg   <= DW'(1);
            seed_pprev_reg  <= '0;
            bit_cnt_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_idx_reg   <= write_idx_next;
            partner_idx_reg <= partner_idx_next;
            seed_idx_reg    <= seed_idx_next;
            seed_prev_reg   <= seed_prev_next;
            seed_pprev_reg  <= seed_pprev_next;
            bit_cnt_reg     <= bit_cnt_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg      <= divisor_next;
        dividend_reg     <= dividend_next;
        rem_reg          <= rem_next;
        random_value_reg <= random_value_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        write_idx_next    = write_idx_reg;
        partner_idx_next  = partner_idx_reg;
        seed_idx_next     = seed_idx_reg;
        seed_prev_next    = seed_prev_reg;
        seed_pprev_next   = seed_pprev_reg;
        bit_cnt_next      = bit_cnt_reg;
        divisor_next      = divisor_reg;
        dividend_next     = dividend_reg;
        rem_next          = rem_reg;
        random_value_next = random_value_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        mem_we            = 1'b0;
        mem_waddr         = AW'(write_idx_reg - IDX_ONE);
        mem_wdata         = table_sum;

        unique case (state_reg)
            lfm_pkg::ST_SEED:
            begin
                mem_we          = 1'b1;
                mem_waddr       = AW'(seed_idx_reg - IDX_ONE);
                mem_wdata       = seed_sum;
                seed_pprev_next = seed_prev_reg;
                seed_prev_next  = seed_sum;
                seed_idx_next   = seed_idx_reg - IDX_ONE;
                if (seed_idx_reg == IDX_ONE)
                begin
                    state_next = lfm_pkg::ST_IDLE;
                end
            end
            lfm_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    divisor_next = req.modulus;
                    state_next   = lfm_pkg::ST_ADD;
                end
            end
            lfm_pkg::ST_ADD:
            begin
                mem_we           = 1'b1;
                dividend_next    = table_sum;
                rem_next         = '0;
                bit_cnt_next     = '0;
                write_idx_next   = step_down(write_idx_reg);
                partner_idx_next = step_down(partner_idx_reg);
                state_next       = lfm_pkg::ST_DIV;
            end
            lfm_pkg::ST_DIV:
            begin
                // shift in the next sum bit, subtract the divisor if it fits
                rem_next      = diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
                dividend_next = {dividend_reg[DW-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + CW'(1);
                if (bit_cnt_reg == CNT_LAST)
                begin
                    state_next = lfm_pkg::ST_FINISH;
                end
            end
            lfm_pkg::ST_FINISH:
            begin
                if (rsp_free)
                begin
                    random_value_next = rem_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = lfm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfm_pkg::ST_IDLE;
            end
        endcase
    end

    `LFM_ASSERT_NEXT(a_accept_starts_add, req_fire, state_reg == lfm_pkg::ST_ADD,
        "accepted request did not start the table add")
    `LFM_ASSERT(a_rem_below_divisor,
        (state_reg == lfm_pkg::ST_FINISH && divisor_reg != '0) |-> (rem_reg < divisor_reg),
        "remainder not below divisor at end of division")
    `LFM_ASSERT(a_index_range,
        write_idx_reg >= IDX_ONE && write_idx_reg <= IDX_TOP &&
        partner_idx_reg >= IDX_ONE && partner_idx_reg <= IDX_TOP,
        "table index out of range")
    `LFM_ASSERT_NEXT(a_add_steps_index, state_reg == lfm_pkg::ST_ADD,
        write_idx_reg == step_down($past(write_idx_reg)),
        "write index did not step down after the add")

endmodule

`default_nettype wire

// ----- test/lagged_fibonacci_modulo_rng_tb.sv -----
`timescale 1ns / 1ps

module lagged_fibonacci_modulo_rng_tb;

    localparam int DATA_W         = lfm_pkg::DATA_W;
    localparam int LAG_DEPTH      = lfm_pkg::TABLE_DEPTH_DEF;
    localparam int LAG_PARTNER    = ((lfm_pkg::PARTNER_START_DEF - 1) % LAG_DEPTH) + 1;
    localparam int RANDOM_BEATS   = 640;
    localparam int HOLD_OFF_BEAT  = 100;
    localparam int DRAIN_BEAT     = 350;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 50;

    typedef struct packed {
        logic [DATA_W-1:0] modulus;
        logic              value_known;
        logic [DATA_W-1:0] known_value;
    } request_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lfm_req_if req_bus ();
    lfm_rsp_if rsp_bus ();

    lagged_fibonacci_modulo_rng i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    logic [DATA_W-1:0] lag_words [1:LAG_DEPTH];
    int unsigned       write_slot;
    int unsigned       partner_slot;

    logic [DATA_W-1:0] pending_values [$];
    int unsigned       mismatch_count = 0;
    int unsigned       idle_cycles    = 0;

    logic              row_known = 1'b0;
    logic [DATA_W-1:0] row_value = '0;
    logic              hold_off_request = 1'b0;

    request_row_t opening_rows [20];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic seed_generator();
        lag_words[LAG_DEPTH]     = 32'd1;
        lag_words[LAG_DEPTH - 1] = 32'd2;
        for (int n = LAG_DEPTH - 2; n > 0; n--)
        begin
            lag_words[n] = lag_words[n + 1] + lag_words[n + 2];
        end
        write_slot   = LAG_DEPTH;
        partner_slot = LAG_PARTNER;
    endtask

    function automatic logic [DATA_W-1:0] advance_generator(input logic [DATA_W-1:0] divisor);
        logic [DATA_W-1:0] total;
        total                 = lag_words[write_slot] + lag_words[partner_slot];
        lag_words[write_slot] = total;
        write_slot            = (write_slot <= 1) ? LAG_DEPTH : write_slot - 1;
        partner_slot          = (partner_slot <= 1) ? LAG_DEPTH : partner_slot - 1;
        return (divisor == '0) ? total : total % divisor;
    endfunction

    function automatic logic [DATA_W-1:0] random_modulus();
        logic [DATA_W-1:0] pick;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick = $urandom;
            4, 5:       pick = $urandom_range(1, 100);
            6:          pick = 32'd1 << $urandom_range(0, 31);
            7:          pick = '0;
            8:          pick = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default:    pick = $urandom >> $urandom_range(1, 31);
        endcase
        return pick;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("mismatch at %0t: %s, random_value 0x%08h, expected 0x%08h",
                     $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic issue_request(input logic [DATA_W-1:0] divisor, input logic known,
                                 input logic [DATA_W-1:0] value);
        @(negedge clk);
        row_known        = known;
        row_value        = value;
        req_bus.valid   <= 1'b1;
        req_bus.modulus <= divisor;
        do
        begin
            @(posedge clk);
        end
        while (!req_bus.ready);
    endtask

    always @(posedge clk)
    begin
        logic [DATA_W-1:0] want;
        if (rst_n)
        begin
            idle_cycles++;
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                idle_cycles = 0;
                if (pending_values.size() == 0)
                begin
                    flag_mismatch("beat with nothing pending", rsp_bus.random_value, '0);
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (rsp_bus.random_value !== want)
                    begin
                        flag_mismatch("wrong value", rsp_bus.random_value, want);
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                idle_cycles = 0;
                want = advance_generator(req_bus.modulus);
                pending_values.push_back(row_known ? row_value : want);
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned stall_phase;
        int unsigned hold_left;
        logic        ready_next;
        stall_phase   = 0;
        hold_left     = 0;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            stall_phase++;
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_OFF_LEN;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case ((stall_phase / 256) % 4)
                    0:       ready_next = 1'b1;
                    1:       ready_next = 1'($urandom_range(0, 1));
                    2:       ready_next = (stall_phase % 5) != 0;
                    default: ready_next = (stall_phase % 64) >= 40;
                endcase
            end
            rsp_bus.ready <= ready_next;
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned burst_left;
        req_bus.valid   = 1'b0;
        req_bus.modulus = '0;
        rst_n           = 1'b0;

        opening_rows[0]  = '{32'd0,          1'b1, 32'd378};
        opening_rows[1]  = '{32'hFFFF_FFFF,  1'b1, 32'd612};
        opening_rows[2]  = '{32'd1,          1'b1, 32'd0};
        opening_rows[3]  = '{32'd2,          1'b1, 32'd0};
        opening_rows[4]  = '{32'd1000,       1'b1, 32'd592};
        opening_rows[5]  = '{32'd10,         1'b1, 32'd1};
        opening_rows[6]  = '{32'h8000_0000,  1'b0, 32'd0};
        opening_rows[7]  = '{32'h7FFF_FFFF,  1'b0, 32'd0};
        opening_rows[8]  = '{32'd3,          1'b0, 32'd0};
        opening_rows[9]  = '{32'd7,          1'b0, 32'd0};
        opening_rows[10] = '{32'h0001_0000,  1'b0, 32'd0};
        opening_rows[11] = '{32'd0,          1'b0, 32'd0};
        opening_rows[12] = '{32'hFFFF_FFFE,  1'b0, 32'd0};
        opening_rows[13] = '{32'hAAAA_AAAA,  1'b0, 32'd0};
        opening_rows[14] = '{32'h5555_5555,  1'b0, 32'd0};
        opening_rows[15] = '{32'h0000_FFFF,  1'b0, 32'd0};
        opening_rows[16] = '{32'h1234_5678,  1'b0, 32'd0};
        opening_rows[17] = '{32'd0,          1'b0, 32'd0};
        opening_rows[18] = '{32'd13,         1'b0, 32'd0};
        opening_rows[19] = '{32'hFEDC_BA98,  1'b0, 32'd0};

        seed_generator();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening_rows[i])
        begin
            issue_request(opening_rows[i].modulus, opening_rows[i].value_known,
                          opening_rows[i].known_value);
        end

        sent       = 0;
        burst_left = $urandom_range(1, 12);
        while (sent < RANDOM_BEATS)
        begin
            if (sent == HOLD_OFF_BEAT)
            begin
                hold_off_request = 1'b1;
            end
            if (sent == DRAIN_BEAT)
            begin
                @(negedge clk);
                req_bus.valid <= 1'b0;
                while (pending_values.size() != 0) @(posedge clk);
            end
            issue_request(random_modulus(), 1'b0, '0);
            sent++;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                // drop valid for a gap, then start a new burst
                @(negedge clk);
                req_bus.valid <= 1'b0;
                repeat ($urandom_range(0, 60)) @(negedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(0, 10);
            end
        end
        @(negedge clk);
        req_bus.valid <= 1'b0;

        while (pending_values.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lfm_pkg.sv
rtl/core/lfm_if.sv
rtl/core/lagged_fibonacci_modulo_rng.sv
test/lagged_fibonacci_modulo_rng_tb.sv
